// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ----- rtl/imts_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Payload types, mode codes and controller status codes.
// ----------------------------------------------------------------------------
package imts_pkg;

    localparam int BUF_DEPTH_DEF = 16;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;

    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_WADDR_ACK  = 8'h18;
    localparam logic [7:0] ST_WADDR_NACK = 8'h20;
    localparam logic [7:0] ST_WDATA_ACK  = 8'h28;
    localparam logic [7:0] ST_RADDR_ACK  = 8'h40;
    localparam logic [7:0] ST_RDATA_ACK  = 8'h50;
    localparam logic [7:0] ST_RDATA_NACK = 8'h58;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [1:0] mode;
        t_byte      data_byte;
        t_byte      slave_address;
        logic [4:0] read_length;
        t_byte      status_code;
    } t_in_item;

    typedef struct packed {
        t_byte      data_out;
        logic       data_out_valid;
        logic       ctl_valid;
        logic       set_start;
        logic       set_stop;
        logic       ack_enable;
        logic       transfer_done;
        logic       rx_valid;
        logic [3:0] rx_index;
        t_byte      rx_byte;
    } t_out_item;

endpackage

// ----- rtl/imts_if.sv -----
// ----------------------------------------------------------------------------
// I2C master transfer sequencer channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface imts_in_if;
    logic               valid;
    logic               ready;
    imts_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface imts_out_if;
    logic                valid;
    logic                ready;
    imts_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/i2c_master_transfer_sequencer.sv -----
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Turns controller status codes into address, data and START/STOP/ACK
// controls; keeps write and receive bytes in a synchronous buffer memory.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+-------------------------------------------------------
//  i_in     | in  | mode, data_byte, slave_address, read_length, status_code
//  o_out    | out | data_out, controls, transfer_done, rx_valid/index/byte
//
//  One transfer per cycle while i_in.ready is high; one result per transfer.
//  The read stage holds the buffer memory read (registered read port).
//  Synchronous active-low reset clears the counters, address and done flag;
//  the buffer needs no clearing pass.
//  A stalled output holds the result register; one more transfer is taken
//  into the read stage, then i_in.ready drops until o_out moves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_transfer_sequencer #(
    parameter int BUF_DEPTH = imts_pkg::BUF_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    imts_in_if.sink        i_in,
    imts_out_if.source     o_out
);

    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int LW = (CW > 5) ? CW : 5;
    localparam int XW = (CW > 4) ? CW : 4;

    imts_pkg::t_in_item  din;
    imts_pkg::t_out_item s0_res;
    imts_pkg::t_out_item s1_res;

    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_offset, n_offset;
    imts_pkg::t_byte r_addr, n_addr;
    logic          r_done, n_done;

    imts_pkg::t_byte     r_mem [BUF_DEPTH];
    imts_pkg::t_byte     r_rd_data;
    logic                r_s1_valid;
    imts_pkg::t_out_item r_s1;
    logic                r_s1_mem;
    logic                r_out_valid;
    imts_pkg::t_out_item r_out;

    logic          in_acc;
    logic          s1_adv;
    logic          mem_we;
    logic          mem_re;
    logic          s0_mem;
    logic [AW-1:0] mem_waddr;
    logic [LW-1:0] rlen_ext;
    logic [LW-1:0] rlen_sat;
    logic [XW-1:0] offset_x;
    logic [CW:0]   off_p1;
    logic [CW:0]   off_p2;
    logic          off_lt_len;
    logic          off_lt_depth;

    assign din    = i_in.data;
    assign s1_adv = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || !r_out_valid || o_out.ready;
    assign in_acc = i_in.valid && i_in.ready;

    assign rlen_ext     = LW'(din.read_length);
    assign rlen_sat     = (rlen_ext > LW'(BUF_DEPTH)) ? LW'(BUF_DEPTH) : rlen_ext;
    assign offset_x     = XW'(r_offset);
    assign off_p1       = (CW+1)'(r_offset) + (CW+1)'(1);
    assign off_p2       = (CW+1)'(r_offset) + (CW+1)'(2);
    assign off_lt_len   = r_offset < r_len;
    assign off_lt_depth = r_offset < CW'(BUF_DEPTH);

    always_comb begin
        n_len     = r_len;
        n_offset  = r_offset;
        n_addr    = r_addr;
        n_done    = r_done;
        s0_res    = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        s0_mem    = 1'b0;
        mem_waddr = r_offset[AW-1:0];
        case (din.mode)
            imts_pkg::MODE_APPEND: begin
                if (r_len < CW'(BUF_DEPTH)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_len[AW-1:0];
                    n_len     = r_len + CW'(1);
                end
            end
            imts_pkg::MODE_START: begin
                n_addr = din.slave_address;
                n_done = 1'b0;
                if (din.slave_address[0]) begin
                    n_len = CW'(rlen_sat);
                end
                s0_res.ctl_valid  = 1'b1;
                s0_res.set_start  = 1'b1;
                s0_res.ack_enable = 1'b1;
            end
            imts_pkg::MODE_STATUS: begin
                case (din.status_code)
                    imts_pkg::ST_START, imts_pkg::ST_RSTART: begin
                        s0_res.data_out       = r_addr;
                        s0_res.data_out_valid = 1'b1;
                        n_offset              = '0;
                        s0_res.ctl_valid      = 1'b1;
                        s0_res.ack_enable     = 1'b1;
                    end
                    imts_pkg::ST_WADDR_ACK, imts_pkg::ST_WDATA_ACK: begin
                        if (off_lt_len && off_lt_depth) begin
                            mem_re                = 1'b1;
                            s0_mem                = 1'b1;
                            s0_res.data_out_valid = 1'b1;
                            n_offset              = r_offset + CW'(1);
                            s0_res.ctl_valid      = 1'b1;
                            s0_res.ack_enable     = 1'b1;
                        end else begin
                            n_len             = '0;
                            n_done            = 1'b1;
                            s0_res.ctl_valid  = 1'b1;
                            s0_res.set_stop   = 1'b1;
                            s0_res.ack_enable = 1'b1;
                        end
                    end
                    imts_pkg::ST_RADDR_ACK: begin
                        if (off_lt_len) begin
                            s0_res.ctl_valid  = 1'b1;
                            s0_res.ack_enable = off_p1 < (CW+1)'(r_len);
                        end
                    end
                    imts_pkg::ST_RDATA_ACK: begin
                        if (off_lt_len) begin
                            mem_we            = 1'b1;
                            s0_res.rx_valid   = 1'b1;
                            s0_res.rx_index   = offset_x[3:0];
                            s0_res.rx_byte    = din.data_byte;
                            n_offset          = r_offset + CW'(1);
                            s0_res.ctl_valid  = 1'b1;
                            s0_res.ack_enable = off_p2 < (CW+1)'(r_len);
                        end
                    end
                    imts_pkg::ST_RDATA_NACK: begin
                        if (off_lt_depth) begin
                            mem_we          = 1'b1;
                            s0_res.rx_valid = 1'b1;
                            s0_res.rx_index = offset_x[3:0];
                            s0_res.rx_byte  = din.data_byte;
                            n_offset        = r_offset + CW'(1);
                        end
                        n_done            = 1'b1;
                        s0_res.ctl_valid  = 1'b1;
                        s0_res.set_stop   = 1'b1;
                        s0_res.ack_enable = 1'b1;
                    end
                    imts_pkg::ST_WADDR_NACK: begin
                        n_done            = 1'b1;
                        s0_res.ctl_valid  = 1'b1;
                        s0_res.set_stop   = 1'b1;
                        s0_res.ack_enable = 1'b1;
                    end
                    default: begin
                        n_done            = 1'b1;
                        s0_res.ctl_valid  = 1'b1;
                        s0_res.set_stop   = 1'b1;
                        s0_res.ack_enable = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
        s0_res.transfer_done = n_done;
    end

    // buffer memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc && mem_we) begin
            r_mem[mem_waddr] <= din.data_byte;
        end
        if (in_acc && mem_re) begin
            r_rd_data <= r_mem[r_offset[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_offset    <= '0;
            r_addr      <= '0;
            r_done      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_len    <= n_len;
                r_offset <= n_offset;
                r_addr   <= n_addr;
                r_done   <= n_done;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        s1_res = r_s1;
        if (r_s1_mem) begin
            s1_res.data_out = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1     <= s0_res;
            r_s1_mem <= s0_mem;
        end
        if (s1_adv) begin
            r_out <= s1_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `ASSERT_NEXT(a_acc_fills_s1, i_clk, i_rst_n, in_acc, r_s1_valid)
    `ASSERT_NEXT(a_rd_hold, i_clk, i_rst_n, r_s1_valid && !s1_adv && !in_acc, $stable(r_rd_data))
    `ASSERT_IMPL(a_rx_has_ctl, i_clk, i_rst_n, r_out_valid && r_out.rx_valid, r_out.ctl_valid)
    `ASSERT_NEXT(a_start_clears_done, i_clk, i_rst_n, in_acc && (din.mode == imts_pkg::MODE_START), !r_done)

endmodule

// ----- dv/i2c_master_transfer_sequencer_test.sv -----
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// I2C master transfer sequencer testbench
// Feeds append, start and controller status transfers through the input
// channel and checks every result against a cycle-free shadow of the
// sequencer. It opens with directed cases and then sends random write and read
// bursts with noise. The three phases use different idle mixes, and one long
// output hold is included.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_test;

    localparam int         DEPTH        = imts_pkg::BUF_DEPTH_DEF;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam logic [7:0] ST_UNDEFINED = 8'hFF;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         PHASE_ITEMS  = 520;
    localparam int         HOLD_CYCLES  = 80;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    imts_in_if  in_ch ();
    imts_out_if out_ch ();

    i2c_master_transfer_sequencer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    imts_pkg::t_byte shadow_buf [DEPTH];
    int unsigned     xfer_len    = 0;
    int unsigned     byte_ofs    = 0;
    imts_pkg::t_byte target_addr = '0;
    logic            done_flag   = 1'b0;

    imts_pkg::t_in_item  outbound    [$];
    imts_pkg::t_out_item due_results [$];

    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    int   hold_len     = 0;
    int   hold_cnt     = 0;
    logic hold_armed   = 1'b0;
    logic in_taken     = 1'b0;
    int   stall_cycles = 0;
    int   fail_count   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void capture_rx(input imts_pkg::t_byte value,
                                       inout imts_pkg::t_out_item res);
        if (byte_ofs < DEPTH) begin
            shadow_buf[byte_ofs] = value;
            res.rx_valid = 1'b1;
            res.rx_index = byte_ofs[3:0];
            res.rx_byte  = value;
            byte_ofs++;
        end
    endfunction

    function automatic imts_pkg::t_out_item sequencer_step(input imts_pkg::t_in_item it);
        imts_pkg::t_out_item res;
        res = '0;
        case (it.mode)
            imts_pkg::MODE_APPEND: begin
                if (xfer_len < DEPTH) begin
                    shadow_buf[xfer_len] = it.data_byte;
                    xfer_len++;
                end
            end
            imts_pkg::MODE_START: begin
                target_addr = it.slave_address;
                done_flag   = 1'b0;
                if (it.slave_address[0])
                    xfer_len = (it.read_length > DEPTH) ? DEPTH : it.read_length;
                res.ctl_valid  = 1'b1;
                res.set_start  = 1'b1;
                res.ack_enable = 1'b1;
            end
            imts_pkg::MODE_STATUS: begin
                case (it.status_code)
                    imts_pkg::ST_START, imts_pkg::ST_RSTART: begin
                        res.data_out       = target_addr;
                        res.data_out_valid = 1'b1;
                        byte_ofs           = 0;
                        res.ctl_valid      = 1'b1;
                        res.ack_enable     = 1'b1;
                    end
                    imts_pkg::ST_WADDR_ACK, imts_pkg::ST_WDATA_ACK: begin
                        res.ctl_valid  = 1'b1;
                        res.ack_enable = 1'b1;
                        if (byte_ofs < xfer_len && byte_ofs < DEPTH) begin
                            res.data_out       = shadow_buf[byte_ofs];
                            res.data_out_valid = 1'b1;
                            byte_ofs++;
                        end else begin
                            xfer_len     = 0;
                            done_flag    = 1'b1;
                            res.set_stop = 1'b1;
                        end
                    end
                    imts_pkg::ST_RADDR_ACK: begin
                        if (byte_ofs < xfer_len) begin
                            res.ctl_valid  = 1'b1;
                            res.ack_enable = (byte_ofs + 1 < xfer_len);
                        end
                    end
                    imts_pkg::ST_RDATA_ACK: begin
                        if (byte_ofs < xfer_len) begin
                            capture_rx(it.data_byte, res);
                            res.ctl_valid  = 1'b1;
                            res.ack_enable = (byte_ofs + 1 < xfer_len);
                        end
                    end
                    imts_pkg::ST_RDATA_NACK: begin
                        capture_rx(it.data_byte, res);
                        done_flag      = 1'b1;
                        res.ctl_valid  = 1'b1;
                        res.set_stop   = 1'b1;
                        res.ack_enable = 1'b1;
                    end
                    default: begin
                        done_flag      = 1'b1;
                        res.ctl_valid  = 1'b1;
                        res.set_stop   = 1'b1;
                        res.ack_enable = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
        res.transfer_done = done_flag;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic void compare_result(input imts_pkg::t_out_item want,
                                           input imts_pkg::t_out_item got);
        check_field("data_out", want.data_out, got.data_out);
        check_field("data_out_valid", want.data_out_valid, got.data_out_valid);
        check_field("ctl_valid", want.ctl_valid, got.ctl_valid);
        check_field("set_start", want.set_start, got.set_start);
        check_field("set_stop", want.set_stop, got.set_stop);
        check_field("ack_enable", want.ack_enable, got.ack_enable);
        check_field("transfer_done", want.transfer_done, got.transfer_done);
        check_field("rx_valid", want.rx_valid, got.rx_valid);
        check_field("rx_index", want.rx_index, got.rx_index);
        check_field("rx_byte", want.rx_byte, got.rx_byte);
    endfunction

    function automatic imts_pkg::t_in_item rand_item(input logic [1:0] mode);
        imts_pkg::t_in_item it;
        it.mode          = mode;
        it.data_byte     = 8'($urandom_range(255));
        it.slave_address = 8'($urandom_range(255));
        it.read_length   = 5'($urandom_range(31));
        it.status_code   = 8'($urandom_range(255));
        return it;
    endfunction

    task automatic push_status(input imts_pkg::t_byte code);
        imts_pkg::t_in_item it;
        it             = rand_item(imts_pkg::MODE_STATUS);
        it.status_code = code;
        outbound.push_back(it);
    endtask

    task automatic push_start(input imts_pkg::t_byte addr, input logic [4:0] rlen);
        imts_pkg::t_in_item it;
        it               = rand_item(imts_pkg::MODE_START);
        it.slave_address = addr;
        it.read_length   = rlen;
        outbound.push_back(it);
    endtask

    task automatic gen_write_burst();
        int n;
        int k;
        int j;
        n = ($urandom_range(9) == 0) ? $urandom_range(5, DEPTH) : $urandom_range(1, 4);
        for (j = 0; j < n; j++)
            outbound.push_back(rand_item(imts_pkg::MODE_APPEND));
        push_start({8'($urandom_range(255))} & 8'hFE, 5'($urandom_range(31)));
        push_status($urandom_range(1) ? imts_pkg::ST_START : imts_pkg::ST_RSTART);
        if ($urandom_range(7) == 0) begin
            push_status(imts_pkg::ST_WADDR_NACK);
        end else begin
            push_status(imts_pkg::ST_WADDR_ACK);
            k = ($urandom_range(7) == 0) ? $urandom_range(n) : n;
            for (j = 0; j < k; j++)
                push_status(imts_pkg::ST_WDATA_ACK);
        end
    endtask

    task automatic gen_read_burst();
        int pick;
        int r;
        int eff;
        int k;
        int j;
        pick = $urandom_range(19);
        if (pick == 0)
            r = 0;
        else if (pick < 3)
            r = $urandom_range(17, 31);
        else if (pick < 6)
            r = $urandom_range(5, DEPTH);
        else
            r = $urandom_range(1, 4);
        eff = (r > DEPTH) ? DEPTH : r;
        push_start({8'($urandom_range(255))} | 8'h01, 5'(r));
        push_status($urandom_range(1) ? imts_pkg::ST_START : imts_pkg::ST_RSTART);
        push_status(imts_pkg::ST_RADDR_ACK);
        k = (eff == 0) ? 0 : eff - 1;
        // overrun the read now and then, more often at full depth
        if ($urandom_range(eff == DEPTH ? 2 : 5) == 0)
            k = eff;
        for (j = 0; j < k; j++)
            push_status(imts_pkg::ST_RDATA_ACK);
        push_status(imts_pkg::ST_RDATA_NACK);
    endtask

    task automatic gen_traffic(input int n_items);
        int goal;
        int pick;
        goal = outbound.size() + n_items;
        while (outbound.size() < goal) begin
            pick = $urandom_range(99);
            if (pick < 45)
                gen_write_burst();
            else if (pick < 85)
                gen_read_burst();
            else
                outbound.push_back(rand_item(2'($urandom_range(3))));
        end
    endtask

    task automatic wait_drained();
        while (outbound.size() != 0 || due_results.size() != 0)
            @(posedge i_clk);
    endtask

    // driver: hold an offered transfer until taken
    always @(negedge i_clk) begin
        if (i_rst_n && !(in_ch.valid && !in_taken)) begin
            if (outbound.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= outbound[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_armed && hold_len > 0) begin
                hold_cnt      <= hold_len;
                hold_armed    <= 1'b1;
                out_ch.ready  <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt      <= hold_cnt - 1;
                out_ch.ready  <= 1'b0;
            end else begin
                out_ch.ready  <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // monitor: check results, then advance the shadow on each input transfer
    always @(posedge i_clk) begin
        imts_pkg::t_out_item want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (due_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, out_ch.data);
                end else begin
                    want = due_results.pop_front();
                    compare_result(want, out_ch.data);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                void'(outbound.pop_front());
                due_results.push_back(sequencer_step(in_ch.data));
            end
            in_taken <= in_ch.valid && in_ch.ready;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("i2c_master_transfer_sequencer_test: FAIL");
            $finish;
        end
    end

    initial begin
        int i;
        imts_pkg::t_in_item it;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        src_idle_pct = 21;
        snk_idle_pct = 58;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill every buffer entry first, extremes at both ends
        for (i = 0; i < DEPTH; i++) begin
            it           = rand_item(imts_pkg::MODE_APPEND);
            it.data_byte = 8'(i * 17);
            outbound.push_back(it);
        end
        push_start(8'h00, 5'd31);
        push_status(imts_pkg::ST_START);
        push_status(imts_pkg::ST_WADDR_ACK);
        push_status(imts_pkg::ST_WDATA_ACK);
        push_status(imts_pkg::ST_WADDR_NACK);
        // long read request saturates, then an append hits the full buffer
        push_start(8'hFF, 5'd31);
        outbound.push_back(rand_item(imts_pkg::MODE_APPEND));
        push_status(imts_pkg::ST_RSTART);
        push_status(imts_pkg::ST_RADDR_ACK);
        push_status(imts_pkg::ST_RDATA_NACK);
        // one-byte read NACKs at once, then two receives, the second with nothing left
        push_start(8'h01, 5'd1);
        push_status(imts_pkg::ST_START);
        push_status(imts_pkg::ST_RADDR_ACK);
        push_status(imts_pkg::ST_RDATA_ACK);
        push_status(imts_pkg::ST_RDATA_ACK);
        outbound.push_back(rand_item(MODE_UNUSED));
        push_status(ST_UNDEFINED);

        gen_traffic(PHASE_ITEMS);
        wait_drained();

        src_idle_pct = 58;
        snk_idle_pct = 21;
        gen_traffic(PHASE_ITEMS);
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_len     = HOLD_CYCLES;
        gen_traffic(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("i2c_master_transfer_sequencer_test: PASS");
        else
            $display("i2c_master_transfer_sequencer_test: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/imts_pkg.sv
rtl/imts_if.sv
rtl/i2c_master_transfer_sequencer.sv
dv/i2c_master_transfer_sequencer_test.sv
